FILE: sv/mma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_pkg
// Shared widths and default sizes of the multichannel moving average block.
// ----------------------------------------------------------------------------
package mma_pkg;

  // fixed field widths of the sample and result transactions
  localparam int SAMPLE_W = 10;
  localparam int CH_W     = 3;

  // default sizing of the averaging windows
  localparam int NUM_CHANNELS_DEF = 6;
  localparam int WINDOW_LEN_DEF   = 20;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage : mma_pkg
`default_nettype wire

FILE: sv/mma_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_front
// Accepts samples, checks the channel, forms the window address from the
// shared write position and advances that position after the last channel.
// ----------------------------------------------------------------------------
module mma_front #(
  parameter int NUM_CHANNELS = mma_pkg::NUM_CHANNELS_DEF,
  parameter int WINDOW_LEN   = mma_pkg::WINDOW_LEN_DEF,
  localparam int CHI   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int DEPTH = NUM_CHANNELS * WINDOW_LEN,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mma_pkg::CH_W-1:0]    in_channel_index,
  input  wire logic [mma_pkg::SAMPLE_W-1:0] in_adc_sample,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output logic [AW-1:0]                    push_addr,
  output logic [CHI-1:0]                   push_ch,
  output logic [mma_pkg::SAMPLE_W-1:0]     push_sample,
  output logic                             push_in_range
);

  localparam int PW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  logic [PW-1:0] pos_r;
  logic [PW-1:0] pos_nxt;
  logic          accept;
  logic          in_range;
  logic          is_last;
  logic [31:0]   addr_full;

  assign accept   = in_valid && push_ready;
  assign in_stall = !push_ready;
  assign in_range = 32'(in_channel_index) < 32'(NUM_CHANNELS);
  assign is_last  = 32'(in_channel_index) == 32'(NUM_CHANNELS - 1);

  assign addr_full = 32'(in_channel_index) * 32'(WINDOW_LEN) + 32'(pos_r);

  assign push_valid    = in_valid;
  assign push_addr     = addr_full[AW-1:0];
  assign push_ch       = CHI'(in_channel_index);
  assign push_sample   = in_adc_sample;
  assign push_in_range = in_range;

  // position moves on only after the highest channel's transaction
  always_comb begin
    pos_nxt = pos_r;
    if (accept && in_range && is_last) begin
      if (pos_r == PW'(WINDOW_LEN - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule : mma_front
`default_nettype wire

FILE: sv/mma_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_queue
// Small first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module mma_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = mma_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);

  localparam int QPW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [QPW-1:0]    wr_ptr_r;
  logic [QPW-1:0]    wr_ptr_nxt;
  logic [QPW-1:0]    rd_ptr_r;
  logic [QPW-1:0]    rd_ptr_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(DEPTH - 1)) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(DEPTH - 1)) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : mma_queue
`default_nettype wire

FILE: sv/mma_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_back
// Read-modify-write of the sample windows and running totals, then division
// of the total by the window length through a reciprocal multiply.
// ----------------------------------------------------------------------------
module mma_back #(
  parameter int NUM_CHANNELS = mma_pkg::NUM_CHANNELS_DEF,
  parameter int WINDOW_LEN   = mma_pkg::WINDOW_LEN_DEF,
  localparam int CHI   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int DEPTH = NUM_CHANNELS * WINDOW_LEN,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         pop_valid,
  output logic                              pop_ready,
  input  wire logic [AW-1:0]                pop_addr,
  input  wire logic [CHI-1:0]               pop_ch,
  input  wire logic [mma_pkg::SAMPLE_W-1:0] pop_sample,
  input  wire logic                         pop_in_range,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [mma_pkg::SAMPLE_W-1:0]      out_average
);

  localparam int SW  = mma_pkg::SAMPLE_W;
  localparam int TW  = $clog2(WINDOW_LEN * ((1 << SW) - 1) + 1);
  localparam int LW  = $clog2(WINDOW_LEN);
  localparam int SH  = TW + LW;
  localparam int PRW = SH + SW;
  // ceil(2^SH / WINDOW_LEN) gives the exact quotient for every total
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);

  // window memory, entries read as zero until first written
  logic [SW-1:0]    win_mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [TW-1:0]    totals_r [NUM_CHANNELS];

  // update stage
  logic             b_valid_r;
  logic [AW-1:0]    b_addr_r;
  logic [CHI-1:0]   b_ch_r;
  logic [SW-1:0]    b_sample_r;
  logic             b_in_range_r;
  logic [SW-1:0]    rd_data_r;
  logic             fwd_hit_r;
  logic [SW-1:0]    fwd_data_r;

  // divide stage
  logic             c_valid_r;
  logic [TW-1:0]    c_total_r;
  logic             c_in_range_r;

  logic             out_valid_r;
  logic [SW-1:0]    out_average_r;

  logic             out_free;
  logic             c_adv;
  logic             c_free;
  logic             b_adv;
  logic             b_free;
  logic             a_fire;
  logic             b_write;
  logic             fwd_hit_nxt;
  logic [SW-1:0]    old_sample;
  logic [TW-1:0]    new_total;
  logic [PRW-1:0]   prod;
  logic [SW-1:0]    quot;

  assign out_free  = !out_valid_r || !out_stall;
  assign c_adv     = c_valid_r && out_free;
  assign c_free    = !c_valid_r || out_free;
  assign b_adv     = b_valid_r && c_free;
  assign b_free    = !b_valid_r || c_free;
  assign a_fire    = pop_valid && b_free;
  assign pop_ready = b_free;
  assign b_write   = b_adv && b_in_range_r;

  // the transaction leaving the update stage writes after the new one's read
  assign fwd_hit_nxt = b_write && (b_addr_r == pop_addr);

  always_comb begin
    if (fwd_hit_r) begin
      old_sample = fwd_data_r;
    end else if (vld_r[b_addr_r]) begin
      old_sample = rd_data_r;
    end else begin
      old_sample = '0;
    end
  end

  assign new_total = totals_r[b_ch_r] - TW'(old_sample) + TW'(b_sample_r);

  assign prod = PRW'(c_total_r) * PRW'(RECIP);
  assign quot = prod[SH +: SW];

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
      vld_r       <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        totals_r[i] <= '0;
      end
    end else begin
      if (a_fire) begin
        b_valid_r <= 1'b1;
        fwd_hit_r <= fwd_hit_nxt;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        c_valid_r <= 1'b1;
      end else if (c_adv) begin
        c_valid_r <= 1'b0;
      end
      if (c_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (b_write) begin
        vld_r[b_addr_r]  <= 1'b1;
        totals_r[b_ch_r] <= new_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_addr_r     <= pop_addr;
      b_ch_r       <= pop_ch;
      b_sample_r   <= pop_sample;
      b_in_range_r <= pop_in_range;
      rd_data_r    <= win_mem_r[pop_addr];
      fwd_data_r   <= b_sample_r;
    end
    if (b_write) begin
      win_mem_r[b_addr_r] <= b_sample_r;
    end
    if (b_adv) begin
      c_total_r    <= new_total;
      c_in_range_r <= b_in_range_r;
    end
    if (c_adv) begin
      out_average_r <= c_in_range_r ? quot : '0;
    end
  end

endmodule : mma_back
`default_nettype wire

FILE: sv/multichannel_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel moving average over a window of converter samples.
// ----------------------------------------------------------------------------
// Input transactions carry a channel number and a 10-bit sample; each one
// gives exactly one output transaction with the channel's window average.
// Channels are expected round-robin: the shared write position advances
// after each transaction for the highest channel. A channel number out of
// range changes nothing and returns an average of zero.
// Throughput is one transaction per cycle while out_stall is low. After the
// accepting edge a transaction passes the queue slot, the update stage
// (window read-modify-write with registered memory read), the divide stage
// register and the reciprocal multiply into the output register. A queue of
// two entries sits between the classifying front and the update pipeline.
// Synchronous reset clears the write position, running totals and the
// written flags of the window memory, so early averages include zeros.
// While out_stall is high the result holds; the pipeline fills and then
// in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module multichannel_moving_average #(
  parameter int NUM_CHANNELS = mma_pkg::NUM_CHANNELS_DEF,
  parameter int WINDOW_LEN   = mma_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [mma_pkg::CH_W-1:0]     in_channel_index,
  input  wire logic [mma_pkg::SAMPLE_W-1:0] in_adc_sample,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [mma_pkg::SAMPLE_W-1:0]      out_average
);

  localparam int SW     = mma_pkg::SAMPLE_W;
  localparam int CHI    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DEPTH  = NUM_CHANNELS * WINDOW_LEN;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = AW + CHI + SW + 1;

  logic              push_valid;
  logic              push_ready;
  logic [AW-1:0]     push_addr;
  logic [CHI-1:0]    push_ch;
  logic [SW-1:0]     push_sample;
  logic              push_in_range;
  logic [DATA_W-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [DATA_W-1:0] pop_data;

  mma_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .WINDOW_LEN   (WINDOW_LEN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_channel_index (in_channel_index),
    .in_adc_sample    (in_adc_sample),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_addr        (push_addr),
    .push_ch          (push_ch),
    .push_sample      (push_sample),
    .push_in_range    (push_in_range)
  );

  assign push_data = {push_addr, push_ch, push_sample, push_in_range};

  mma_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (mma_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mma_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .WINDOW_LEN   (WINDOW_LEN)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_addr     (pop_data[DATA_W-1 -: AW]),
    .pop_ch       (pop_data[SW+1 +: CHI]),
    .pop_sample   (pop_data[1 +: SW]),
    .pop_in_range (pop_data[0]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_average  (out_average)
  );

endmodule : multichannel_moving_average
`default_nettype wire

FILE: sv/mma_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks of the multichannel moving average block.
// ----------------------------------------------------------------------------
module mma_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [mma_pkg::CH_W-1:0]     in_channel_index,
  input wire logic [mma_pkg::SAMPLE_W-1:0] in_adc_sample,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [mma_pkg::SAMPLE_W-1:0] out_average
);

  // a stalled result transaction holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average))
    else $error("stalled average changed");

  // reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

  // a free output cycle drains the queue enough to take a sample
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(!out_stall) |-> !in_stall)
    else $error("input stalled after free output cycle");

  // an idle input with a free output leaves nothing to stall on
  a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !out_stall |=> !in_stall)
    else $error("input stalled while idle");

endmodule : mma_checker

bind multichannel_moving_average mma_checker u_mma_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_channel_index (in_channel_index),
  .in_adc_sample    (in_adc_sample),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_average      (out_average)
);
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the six-channel moving average filter.
// ----------------------------------------------------------------------------
// Sample transactions come from a queue that the stimulus block fills: a
// short directed set, then round-robin rounds with random, full-scale, near-top
// and zero samples, mixed with broken rounds and out-of-range channels. Every
// accepted sample goes through a local copy of the window store and totals,
// and each output transaction is checked against the oldest predicted
// average. Both sides idle in short random bursts, except near the end.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_CH  = mma_pkg::NUM_CHANNELS_DEF;
  localparam int WIN_LEN = mma_pkg::WINDOW_LEN_DEF;
  localparam int SW      = mma_pkg::SAMPLE_W;
  localparam int CW      = mma_pkg::CH_W;

  localparam int RANDOM_ITEMS   = 750;
  localparam int TAIL_ITEMS     = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [SW-1:0] FULL_SCALE = '1;

  typedef enum int {
    REGIME_RANDOM,
    REGIME_FULL,
    REGIME_ZERO,
    REGIME_NEAR_TOP
  } sample_regime_t;

  typedef struct packed {
    logic [CW-1:0] channel;
    logic [SW-1:0] sample;
  } sample_txn_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [CW-1:0] in_channel_index;
  logic [SW-1:0] in_adc_sample;
  logic          out_valid;
  logic          out_stall;
  logic [SW-1:0] out_average;

  multichannel_moving_average #(
    .NUM_CHANNELS(NUM_CH),
    .WINDOW_LEN  (WIN_LEN)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_channel_index(in_channel_index),
    .in_adc_sample   (in_adc_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average)
  );

  // local copy of the filter state
  logic [SW-1:0] window_mem [NUM_CH][WIN_LEN];
  logic [14:0]   channel_total [NUM_CH];
  logic [4:0]    write_pos;

  sample_txn_t   pending_samples[$];
  logic [SW-1:0] expected_averages[$];
  sample_txn_t   next_txn;

  int  total_items;
  int  accepted_count;
  int  result_count;
  int  ignored_count;
  int  full_scale_count;
  int  mismatch_count;
  int  idle_cycles;
  int  cycle_count;
  int  in_idle_pct;
  int  out_idle_pct;
  int  in_gap_left;
  int  out_gap_left;
  logic in_fired;
  logic tail_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // returns the new window average of the channel and updates the state
  function automatic logic [SW-1:0] update_window_average(input logic [CW-1:0] ch,
                                                          input logic [SW-1:0] sample);
    int pos;
    int total;
    if (ch >= NUM_CH) begin
      return '0;
    end
    pos   = int'(write_pos);
    total = int'(channel_total[ch]) - int'(window_mem[ch][pos]) + int'(sample);
    window_mem[ch][pos] = sample;
    channel_total[ch]   = total[14:0];
    if (ch == NUM_CH - 1) begin
      write_pos = (pos == WIN_LEN - 1) ? 5'd0 : 5'(pos + 1);
    end
    return SW'(total / WIN_LEN);
  endfunction

  function automatic logic [SW-1:0] regime_sample(input sample_regime_t regime);
    case (regime)
      REGIME_FULL:     return FULL_SCALE;
      REGIME_ZERO:     return '0;
      REGIME_NEAR_TOP: return SW'($urandom_range(1000, 1023));
      default:         return SW'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic push_sample(input int ch, input logic [SW-1:0] sample);
    sample_txn_t txn;
    txn.channel = CW'(ch);
    txn.sample  = sample;
    pending_samples.push_back(txn);
  endtask

  // stimulus
  initial begin
    sample_regime_t regime;
    int n_rounds;
    int kind;
    int first_ch;
    int last_ch;

    for (int c = 0; c < NUM_CH; c++) begin
      for (int p = 0; p < WIN_LEN; p++) window_mem[c][p] = '0;
      channel_total[c] = '0;
    end
    write_pos = '0;

    // full scale round, then a zero round
    for (int c = 0; c < NUM_CH; c++) push_sample(c, FULL_SCALE);
    for (int c = 0; c < NUM_CH; c++) push_sample(c, '0);
    // channels past the last one are ignored
    push_sample(NUM_CH, FULL_SCALE);
    push_sample(7, FULL_SCALE);
    // out of order: last channel first, then a repeat
    push_sample(NUM_CH - 1, 10'h155);
    push_sample(0, 10'h2AA);
    push_sample(2, FULL_SCALE);
    push_sample(2, 10'h001);
    for (int c = 0; c < NUM_CH; c++) push_sample(c, (c % 2 == 0) ? 10'h2AA : 10'h155);

    while (pending_samples.size() < RANDOM_ITEMS) begin
      regime   = sample_regime_t'($urandom_range(0, 3));
      n_rounds = $urandom_range(1, 25);
      for (int r = 0; r < n_rounds && pending_samples.size() < RANDOM_ITEMS; r++) begin
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
          for (int c = 0; c < NUM_CH; c++) push_sample(c, regime_sample(regime));
        end else if (kind < 93) begin
          // broken round: a random slice of the channels
          first_ch = $urandom_range(0, NUM_CH - 1);
          last_ch  = $urandom_range(first_ch, NUM_CH - 1);
          for (int c = first_ch; c <= last_ch; c++) push_sample(c, regime_sample(regime));
        end else begin
          for (int k = 0; k < $urandom_range(1, 4); k++) begin
            push_sample($urandom_range(0, 7), SW'($urandom_range(0, 1023)));
          end
        end
      end
    end
    total_items = pending_samples.size();

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_channel_index = '0;
    in_adc_sample    = '0;
    out_stall        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (accepted_count < total_items || expected_averages.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (expected_averages.size() > 0) begin
      mismatch_count++;
      $display("%0d averages never arrived", expected_averages.size());
    end
    $display("accepted %0d samples (%0d on ignored channels), checked %0d averages",
             accepted_count, ignored_count, result_count);
    $display("full-scale averages seen: %0d, mismatches: %0d",
             full_scale_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // sample driver
  always @(negedge clk) begin
    tail_phase <= pending_samples.size() < TAIL_ITEMS;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fired) begin
      // stalled transaction holds
    end else if (in_gap_left > 0) begin
      in_valid    <= 1'b0;
      in_gap_left <= in_gap_left - 1;
    end else if (!tail_phase && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid    <= 1'b0;
      in_gap_left <= $urandom_range(0, 4);
    end else if (pending_samples.size() > 0) begin
      next_txn         = pending_samples.pop_front();
      in_valid         <= 1'b1;
      in_channel_index <= next_txn.channel;
      in_adc_sample    <= next_txn.sample;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result stall generator
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_gap_left > 0) begin
      out_stall    <= 1'b1;
      out_gap_left <= out_gap_left - 1;
    end else if (!tail_phase && $urandom_range(0, 99) < out_idle_pct) begin
      out_stall    <= 1'b1;
      out_gap_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    logic [SW-1:0] want;
    logic          moved;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      moved = 1'b0;
      in_fired <= in_valid && !in_stall;
      cycle_count++;
      // alternate between calm and busy stretches
      if (cycle_count % 128 == 0) begin
        in_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        out_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end

      if (in_valid && !in_stall) begin
        moved = 1'b1;
        accepted_count++;
        if (in_channel_index >= NUM_CH) ignored_count++;
        expected_averages.push_back(update_window_average(in_channel_index, in_adc_sample));
      end

      if (out_valid && !out_stall) begin
        moved = 1'b1;
        result_count++;
        if (out_average == FULL_SCALE) full_scale_count++;
        if (expected_averages.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected output transaction: average %0d", out_average);
          end
        end else begin
          want = expected_averages.pop_front();
          if (out_average !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("average mismatch on result %0d: expected %0d, got %0d",
                       result_count, want, out_average);
            end
          end
        end
      end

      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    accepted_count   = 0;
    result_count     = 0;
    ignored_count    = 0;
    full_scale_count = 0;
    mismatch_count   = 0;
    idle_cycles      = 0;
    cycle_count      = 0;
    in_idle_pct      = 20;
    out_idle_pct     = 20;
    in_gap_left      = 0;
    out_gap_left     = 0;
    in_fired         = 1'b0;
    tail_phase       = 1'b0;
  end

endmodule : testbench
